// File: hdl/rct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_pkg: shared types and constants of the rotation coordinate transform
// Payload structs, register indexes, register reset values and the decoded
// configuration bundle passed from the register file to the datapath.
// ----------------------------------------------------------------------------
package rct_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 64;

   // input coordinate width, signed Q12.4
   localparam int CoordWidth    = 16;

   // register indexes on the configuration port
   localparam logic [CsrIndexWidth-1:0] RegFwdRow0    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegFwdRow1    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegFwdRow2    = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegInvRow0    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegInvRow1    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] RegInvRow2    = 3'd5;
   localparam logic [CsrIndexWidth-1:0] RegSubInverse = 3'd6;
   localparam logic [CsrIndexWidth-1:0] RegModeScale  = 3'd7;

   // reset values: identity matrices, identity sub-inverse, forward mode,
   // scale and reciprocal scale 1.0
   localparam logic [59:0] RowResetX    = 60'h0000_0000_0001_0000;
   localparam logic [59:0] RowResetY    = 60'h0000_0010_0000_0000;
   localparam logic [59:0] RowResetZ    = 60'h100_0000_0000_0000;
   localparam logic [63:0] SubResetVal  = 64'h0100_0000_0000_0100;
   localparam logic [48:0] ModeResetVal = 49'h0_0200_0002_0000;

   typedef struct packed {
      logic signed [CoordWidth-1:0] coord_x;
      logic signed [CoordWidth-1:0] coord_y;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] scaled_x;
      logic signed [31:0] scaled_y;
      logic signed [31:0] raw_x;
      logic signed [31:0] raw_y;
      logic signed [31:0] raw_z;
   } rsp_payload_type;

   // decoded configuration, rows hold three Q4.16 entries low to high
   typedef struct packed {
      logic [2:0][59:0] fwd_row;
      logic [2:0][59:0] inv_row;
      logic [63:0]      sub_inverse;
      logic             inverse_mode;
      logic [23:0]      scale;
      logic [23:0]      recip_scale;
   } cfg_type;

endpackage

// File: hdl/rct_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_csr: configuration register file
// Write-only registers for the matrices, the sub-inverse and the mode/scale
// word. Writes are masked to register width; decoded fields go out as a struct.
// ----------------------------------------------------------------------------
module rct_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [rct_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [rct_pkg::CsrDataWidth-1:0]     csr_write_data,
   output rct_pkg::cfg_type                     cfg
);

   logic [2:0][59:0] fwd_row_ff;
   logic [2:0][59:0] inv_row_ff;
   logic [63:0]      sub_ff;
   logic [48:0]      mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_row_ff[0] <= rct_pkg::RowResetX;
         fwd_row_ff[1] <= rct_pkg::RowResetY;
         fwd_row_ff[2] <= rct_pkg::RowResetZ;
         inv_row_ff[0] <= rct_pkg::RowResetX;
         inv_row_ff[1] <= rct_pkg::RowResetY;
         inv_row_ff[2] <= rct_pkg::RowResetZ;
         sub_ff        <= rct_pkg::SubResetVal;
         mode_ff       <= rct_pkg::ModeResetVal;
      end else if (csr_write_enable) begin
         case (csr_index)
            rct_pkg::RegFwdRow0:    fwd_row_ff[0] <= csr_write_data[59:0];
            rct_pkg::RegFwdRow1:    fwd_row_ff[1] <= csr_write_data[59:0];
            rct_pkg::RegFwdRow2:    fwd_row_ff[2] <= csr_write_data[59:0];
            rct_pkg::RegInvRow0:    inv_row_ff[0] <= csr_write_data[59:0];
            rct_pkg::RegInvRow1:    inv_row_ff[1] <= csr_write_data[59:0];
            rct_pkg::RegInvRow2:    inv_row_ff[2] <= csr_write_data[59:0];
            rct_pkg::RegSubInverse: sub_ff        <= csr_write_data;
            rct_pkg::RegModeScale:  mode_ff       <= csr_write_data[48:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.fwd_row      = fwd_row_ff;
      cfg.inv_row      = inv_row_ff;
      cfg.sub_inverse  = sub_ff;
      cfg.inverse_mode = mode_ff[0];
      cfg.scale        = mode_ff[24:1];
      cfg.recip_scale  = mode_ff[48:25];
   end

endmodule

// File: hdl/rotation_coordinate_transform_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_coordinate_transform_core: 3x3 rotation of a 2-D tracking point
// Usage:
//   req_*  : one Q12.4 coordinate per transfer (req_valid / req_stall).
//   rsp_*  : scaled x,y and raw x,y,z, Q.4, saturated to 32 bits, one per
//            request, in order (rsp_valid / rsp_stall).
//   csr_*  : write-only register port; write only while the pipe is empty.
//   Forward mode: M_fwd * (x,y,0), x,y times scale.
//   Inverse mode: (u,v) = S*(x,y), z = fwd row 2 . (u,v,0), then
//            M_inv * (x,y,z), x,y times the reciprocal scale.
//   Pipeline: eight register stages between request transfer and rsp_valid,
//   one multiply rank or one add/round rank each.
//   Throughput: one coordinate per cycle while rsp_stall is low; every stage
//   of the multiplier pipeline passes its item on while it takes the next.
//   Stall: rsp_stall holds the output register; each stage keeps moving as
//   long as the stage after it has room, so bubbles close up and req_stall
//   rises only once every stage is full.
//   Reset: synchronous; all stage valid bits clear and the registers return
//   to identity matrices, forward mode, scale 1.0.
// ----------------------------------------------------------------------------
module rotation_coordinate_transform_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rct_pkg::req_payload_type             req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rct_pkg::rsp_payload_type             rsp_payload,
   input  logic                                 csr_write_enable,
   input  logic [rct_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [rct_pkg::CsrDataWidth-1:0]     csr_write_data
);

   localparam int NumStages = 8;

   rct_pkg::cfg_type cfg;

   rct_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // ---------------------------------------------------------------- control
   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages-1:0] move;

   // a stage loads when it is empty or its content moves on
   always_comb begin
      move[NumStages-1] = !valid_ff[NumStages-1] || !rsp_stall;
      for (int s = NumStages - 2; s >= 0; s--) begin
         move[s] = !valid_ff[s] || move[s+1];
      end
      valid_in = {valid_ff[NumStages-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < NumStages; s++) begin
            if (move[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   assign req_stall = !move[0];
   assign rsp_valid = valid_ff[NumStages-1];

   // ---------------------------------------------------------------- datapath
   logic [2:0][59:0] mrow;       // rows of the matrix in use
   logic [23:0]      kval;       // scale or reciprocal scale

   // stage 0: first products
   logic signed [31:0] ps0_in [4];
   logic signed [31:0] ps0_ff [4];
   logic signed [35:0] pm0_in [3][2];
   logic signed [35:0] pm0_ff [3][2];
   // stage 1: u, v and the x,y part of each row
   logic signed [32:0] usum;
   logic signed [32:0] vsum;
   logic signed [24:0] u1_in;
   logic signed [24:0] v1_in;
   logic signed [24:0] u1_ff;
   logic signed [24:0] v1_ff;
   logic signed [36:0] pa1_in [3];
   logic signed [36:0] pa1_ff [3];
   // stage 2: virtual z products
   logic signed [44:0] zq2_in [2];
   logic signed [44:0] zq2_ff [2];
   logic signed [36:0] pa2_ff [3];
   // stage 3: virtual z
   logic signed [45:0] zsum;
   logic signed [29:0] z3_in;
   logic signed [29:0] z3_ff;
   logic signed [36:0] pa3_ff [3];
   // stage 4: z column products
   logic signed [49:0] pz4_in [3];
   logic signed [49:0] pz4_ff [3];
   logic signed [36:0] pa4_ff [3];
   // stage 5: raw result
   logic signed [50:0] acc [3];
   logic signed [34:0] raw5_in [3];
   logic signed [34:0] raw5_ff [3];
   // stage 6: scale products
   logic signed [59:0] sp6_in [2];
   logic signed [59:0] sp6_ff [2];
   logic signed [34:0] raw6_ff [3];
   // stage 7: output register
   logic signed [59:0] ssum [2];
   rct_pkg::rsp_payload_type rsp_in;
   rct_pkg::rsp_payload_type rsp_ff;

   function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
      logic signed [31:0] r;
      if (v > 44'sh000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < 44'shFFF_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         mrow[r] = cfg.inverse_mode ? cfg.inv_row[r] : cfg.fwd_row[r];
      end
      kval = cfg.inverse_mode ? cfg.recip_scale : cfg.scale;

      // stage 0
      ps0_in[0] = $signed(cfg.sub_inverse[15:0])  * req_payload.coord_x;
      ps0_in[1] = $signed(cfg.sub_inverse[31:16]) * req_payload.coord_y;
      ps0_in[2] = $signed(cfg.sub_inverse[47:32]) * req_payload.coord_x;
      ps0_in[3] = $signed(cfg.sub_inverse[63:48]) * req_payload.coord_y;
      for (int r = 0; r < 3; r++) begin
         pm0_in[r][0] = $signed(mrow[r][19:0])  * req_payload.coord_x;
         pm0_in[r][1] = $signed(mrow[r][39:20]) * req_payload.coord_y;
      end

      // stage 1: round half up back to Q.4
      usum  = ps0_ff[0] + ps0_ff[1] + 33'sd128;
      vsum  = ps0_ff[2] + ps0_ff[3] + 33'sd128;
      u1_in = usum[32:8];
      v1_in = vsum[32:8];
      for (int r = 0; r < 3; r++) begin
         pa1_in[r] = pm0_ff[r][0] + pm0_ff[r][1];
      end

      // stage 2: z always uses forward row 2
      zq2_in[0] = $signed(cfg.fwd_row[2][19:0])  * u1_ff;
      zq2_in[1] = $signed(cfg.fwd_row[2][39:20]) * v1_ff;

      // stage 3: |z| stays below 2^28, so the 30-bit z register holds it
      zsum  = zq2_ff[0] + zq2_ff[1] + 46'sd32768;
      z3_in = cfg.inverse_mode ? zsum[45:16] : '0;

      // stage 4
      for (int r = 0; r < 3; r++) begin
         pz4_in[r] = $signed(mrow[r][59:40]) * z3_ff;
      end

      // stage 5
      for (int r = 0; r < 3; r++) begin
         acc[r]     = pa4_ff[r] + pz4_ff[r] + 51'sd32768;
         raw5_in[r] = acc[r][50:16];
      end

      // stage 6: scale from the unsaturated raw value
      sp6_in[0] = raw5_ff[0] * $signed({1'b0, kval});
      sp6_in[1] = raw5_ff[1] * $signed({1'b0, kval});

      // stage 7
      ssum[0] = sp6_ff[0] + 60'sd32768;
      ssum[1] = sp6_ff[1] + 60'sd32768;
      rsp_in.scaled_x = sat32(ssum[0][59:16]);
      rsp_in.scaled_y = sat32(ssum[1][59:16]);
      rsp_in.raw_x    = sat32({{9{raw6_ff[0][34]}}, raw6_ff[0]});
      rsp_in.raw_y    = sat32({{9{raw6_ff[1][34]}}, raw6_ff[1]});
      rsp_in.raw_z    = sat32({{9{raw6_ff[2][34]}}, raw6_ff[2]});
   end

   always_ff @(posedge clock) begin
      if (move[0]) begin
         ps0_ff <= ps0_in;
         pm0_ff <= pm0_in;
      end
      if (move[1]) begin
         u1_ff  <= u1_in;
         v1_ff  <= v1_in;
         pa1_ff <= pa1_in;
      end
      if (move[2]) begin
         zq2_ff <= zq2_in;
         pa2_ff <= pa1_ff;
      end
      if (move[3]) begin
         z3_ff  <= z3_in;
         pa3_ff <= pa2_ff;
      end
      if (move[4]) begin
         pz4_ff <= pz4_in;
         pa4_ff <= pa3_ff;
      end
      if (move[5]) begin
         raw5_ff <= raw5_in;
      end
      if (move[6]) begin
         sp6_ff  <= sp6_in;
         raw6_ff <= raw5_ff;
      end
      if (move[7]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

   // -------------------------------------------------------------- assertions
   // with the output side open the pipe never pushes back
   a_no_stall_when_open : assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("req_stall high while rsp_stall is low");

   // an accepted request occupies the first stage
   a_accept_loads : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted request missing from first stage");

   // a held stage keeps its item and its z value
   a_stage3_hold : assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && !move[3]) |=> (valid_ff[3] && $stable(z3_ff)))
      else $error("stage 3 lost or changed a held item");

   // forward mode feeds a zero z into the third column
   a_fwd_zero_z : assert property (@(posedge clock) disable iff (reset)
      (move[3] && !cfg.inverse_mode) |=> (z3_ff == '0))
      else $error("nonzero z in forward mode");

endmodule
